// ----- rtl/core/dhab_pkg.sv -----
// Shared types, field widths and register codes for the detector head
// argmax and box decode block. No dependencies.
`timescale 1ns / 1ps

package dhab_pkg;

  // Default storage sizes, used as the defaults of the top level parameters
  localparam int unsigned MAX_ANCHORS_DEF = 16384;
  localparam int unsigned MAX_CLASSES_DEF = 128;

  // Fixed field widths
  localparam int CH_W       = 8;
  localparam int ANCHOR_W   = 14;
  localparam int SAMPLE_W   = 16;
  localparam int CLASS_ID_W = 7;
  localparam int SCORE_W    = 15;
  localparam int EXT_W      = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Box channels ahead of the class score channels
  localparam int BOX_CHANNELS = 4;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD   = 3'd0,
    REG_CLASS_COUNT = 3'd1,
    REG_INV_SCALE   = 3'd2,
    REG_PAD_LEFT    = 3'd3,
    REG_PAD_TOP     = 3'd4
  } cfg_reg_t;

  // Box channel lanes
  typedef enum logic [1:0] {
    LANE_CX = 2'd0,
    LANE_CY = 2'd1,
    LANE_W  = 2'd2,
    LANE_H  = 2'd3
  } box_lane_t;

  // Configuration register file
  typedef struct packed {
    logic [SCORE_W-1:0]         threshold;
    logic [CH_W-1:0]            class_count;
    logic [15:0]                inv_scale;
    logic signed [SAMPLE_W-1:0] pad_left;
    logic signed [SAMPLE_W-1:0] pad_top;
  } cfg_t;

  // Classified item; code is the box lane or the class index
  typedef struct packed {
    logic                       is_box;
    logic                       first;
    logic                       last;
    logic [CH_W-1:0]            code;
    logic [ANCHOR_W-1:0]        anchor;
    logic signed [SAMPLE_W-1:0] sample;
  } item_t;

  // Detection identity carried along the decode pipeline
  typedef struct packed {
    logic [ANCHOR_W-1:0] anchor;
    logic [CH_W-1:0]     cls;
    logic [SCORE_W-1:0]  score;
  } meta_t;

  // Detection with its stored box values
  typedef struct packed {
    meta_t                      meta;
    logic signed [SAMPLE_W-1:0] cx;
    logic signed [SAMPLE_W-1:0] cy;
    logic signed [SAMPLE_W-1:0] w;
    logic signed [SAMPLE_W-1:0] h;
  } det_t;

endpackage

// ----- rtl/core/dhab_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module dhab_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/dhab_front.sv -----
// Front end: accepts tensor values, classifies them by channel and queues
// them for the back end. Depends on dhab_pkg.
`timescale 1ns / 1ps

module dhab_front #(
  parameter int unsigned MAX_ANCHORS = dhab_pkg::MAX_ANCHORS_DEF,
  parameter int unsigned MAX_CLASSES = dhab_pkg::MAX_CLASSES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [dhab_pkg::CH_W-1:0]           channel,
  input  logic [dhab_pkg::ANCHOR_W-1:0]       anchor,
  input  logic signed [dhab_pkg::SAMPLE_W-1:0] sample,
  input  dhab_pkg::cfg_t                      cfg,
  output dhab_pkg::item_t                     head,
  output logic                                head_valid,
  input  logic                                pop
);
  import dhab_pkg::*;

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [QPTR_W:0] QFULL = (QPTR_W + 1)'(QUEUE_DEPTH);
  localparam logic [8:0] MAXC = 9'(MAX_CLASSES);
  localparam logic [16:0] MAXA = 17'(MAX_ANCHORS);

  logic [8:0]      n_eff;
  logic [CH_W-1:0] cls_idx;
  logic            keep;
  logic            push;
  item_t           item;

  item_t           q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  // Clamp the class count to the supported range
  always_comb begin
    if (cfg.class_count == '0) begin
      n_eff = 9'd1;
    end else if (9'(cfg.class_count) > MAXC) begin
      n_eff = MAXC;
    end else begin
      n_eff = 9'(cfg.class_count);
    end
  end

  // Classify: box channel, class channel in range, or drop
  always_comb begin
    cls_idx     = channel - CH_W'(BOX_CHANNELS);
    item.is_box = (channel < CH_W'(BOX_CHANNELS));
    item.first  = (cls_idx == '0);
    item.last   = (9'(cls_idx) == n_eff - 9'd1);
    item.code   = item.is_box ? channel : cls_idx;
    item.anchor = anchor;
    item.sample = sample;
    keep        = (17'(anchor) < MAXA) && (item.is_box || (9'(cls_idx) < n_eff));
  end

  assign in_ready   = (count != QFULL);
  assign push       = in_valid && in_ready && keep;
  assign head       = q[rd_ptr];
  assign head_valid = (count != '0);

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= item;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/dhab_score.sv -----
// Back end, first half: per-anchor box store and running argmax as a
// read-modify-write over RAMs with write forwarding. Depends on dhab_pkg,
// dhab_ram.
`timescale 1ns / 1ps

module dhab_score #(
  parameter int unsigned MAX_ANCHORS = dhab_pkg::MAX_ANCHORS_DEF,
  parameter int unsigned MAX_CLASSES = dhab_pkg::MAX_CLASSES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  dhab_pkg::item_t head,
  input  logic            head_valid,
  output logic            pop,
  input  dhab_pkg::cfg_t  cfg,
  output logic            det_valid,
  output dhab_pkg::det_t  det
);
  import dhab_pkg::*;

  localparam int AW = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;
  localparam int CW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int BW = SCORE_W + CW;

  item_t           b_item;
  logic            b_vld;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;

  logic [BW-1:0]   best_rd;
  logic [BW-1:0]   best_cur;
  logic [BW-1:0]   best_new;
  logic            best_we;
  logic [SCORE_W-1:0] base_score;
  logic [CW-1:0]      base_cls;
  logic [SCORE_W-1:0] new_score;
  logic [CW-1:0]      new_cls;

  logic            fb_vld;
  logic [AW-1:0]   fb_addr;
  logic [BW-1:0]   fb_data;

  logic signed [SAMPLE_W-1:0] box_rd  [BOX_CHANNELS];
  logic signed [SAMPLE_W-1:0] box_cur [BOX_CHANNELS];
  logic                       box_we  [BOX_CHANNELS];
  logic                       fx_vld  [BOX_CHANNELS];
  logic [AW-1:0]              fx_addr [BOX_CHANNELS];
  logic signed [SAMPLE_W-1:0] fx_data [BOX_CHANNELS];

  assign pop     = adv && head_valid;
  assign rd_addr = AW'(head.anchor);
  assign wr_addr = AW'(b_item.anchor);

  // Advance the read stage with the back end
  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (adv) begin
      b_vld <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_item <= head;
    end
  end

  // Box lanes: one RAM each, forwarded from the last write of the lane
  for (genvar l = 0; l < BOX_CHANNELS; l++) begin : g_lane
    assign box_we[l] = adv && b_vld && b_item.is_box &&
                       (box_lane_t'(b_item.code[1:0]) == box_lane_t'(l));

    dhab_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_ANCHORS)
    ) u_box_ram (
      .clk   (clk),
      .we    (box_we[l]),
      .waddr (wr_addr),
      .wdata (b_item.sample),
      .re    (adv),
      .raddr (rd_addr),
      .rdata (box_rd[l])
    );

    assign box_cur[l] = (fx_vld[l] && (fx_addr[l] == wr_addr)) ? fx_data[l] : box_rd[l];

    always_ff @(posedge clk) begin
      if (rst) begin
        fx_vld[l] <= 1'b0;
      end else if (box_we[l]) begin
        fx_vld[l] <= 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (box_we[l]) begin
        fx_addr[l] <= wr_addr;
        fx_data[l] <= b_item.sample;
      end
    end
  end

  // Running best score and class
  assign best_we = adv && b_vld && !b_item.is_box;

  dhab_ram #(
    .WIDTH (BW),
    .DEPTH (MAX_ANCHORS)
  ) u_best_ram (
    .clk   (clk),
    .we    (best_we),
    .waddr (wr_addr),
    .wdata (best_new),
    .re    (adv),
    .raddr (rd_addr),
    .rdata (best_rd)
  );

  assign best_cur = (fb_vld && (fb_addr == wr_addr)) ? fb_data : best_rd;

  // Restart on the first class, replace on a strictly greater score
  always_comb begin
    if (b_item.first) begin
      base_score = '0;
      base_cls   = '0;
    end else begin
      base_score = best_cur[BW-1:CW];
      base_cls   = best_cur[CW-1:0];
    end
    if (b_item.sample > $signed({1'b0, base_score})) begin
      new_score = b_item.sample[SCORE_W-1:0];
      new_cls   = CW'(b_item.code);
    end else begin
      new_score = base_score;
      new_cls   = base_cls;
    end
    best_new = {new_score, new_cls};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fb_vld <= 1'b0;
    end else if (best_we) begin
      fb_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (best_we) begin
      fb_addr <= wr_addr;
      fb_data <= best_new;
    end
  end

  // Emit on the last class when the maximum beats the threshold
  assign det_valid = b_vld && !b_item.is_box && b_item.last && (new_score > cfg.threshold);

  always_comb begin
    det.meta.anchor = b_item.anchor;
    det.meta.cls    = CH_W'(new_cls);
    det.meta.score  = new_score;
    det.cx          = box_cur[LANE_CX];
    det.cy          = box_cur[LANE_CY];
    det.w           = box_cur[LANE_W];
    det.h           = box_cur[LANE_H];
  end

endmodule

// ----- rtl/core/dhab_decode.sv -----
// Back end, second half: box decode pipeline (corner terms, scale multiply,
// round and saturate) and the output register. Depends on dhab_pkg.
`timescale 1ns / 1ps

module dhab_decode (
  input  logic                                 clk,
  input  logic                                 rst,
  input  dhab_pkg::cfg_t                       cfg,
  output logic                                 adv,
  input  logic                                 det_valid,
  input  dhab_pkg::det_t                       det,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [dhab_pkg::ANCHOR_W-1:0]        anchor_id,
  output logic [dhab_pkg::CLASS_ID_W-1:0]      class_id,
  output logic [dhab_pkg::SCORE_W-1:0]         confidence,
  output logic signed [dhab_pkg::SAMPLE_W-1:0] box_left,
  output logic signed [dhab_pkg::SAMPLE_W-1:0] box_top,
  output logic [dhab_pkg::EXT_W-1:0]           box_width,
  output logic [dhab_pkg::EXT_W-1:0]           box_height
);
  import dhab_pkg::*;

  localparam int NUM_W  = SAMPLE_W + 3;
  localparam int PC_W   = NUM_W + 17;
  localparam int PE_W   = SAMPLE_W + 17;

  logic                       s2_vld;
  meta_t                      s2_meta;
  logic signed [NUM_W-1:0]    s2_nx;
  logic signed [NUM_W-1:0]    s2_ny;
  logic signed [SAMPLE_W-1:0] s2_w;
  logic signed [SAMPLE_W-1:0] s2_h;
  logic signed [NUM_W-1:0]    nx;
  logic signed [NUM_W-1:0]    ny;

  logic                       s3_vld;
  meta_t                      s3_meta;
  logic signed [PC_W-1:0]     s3_px;
  logic signed [PC_W-1:0]     s3_py;
  logic signed [PE_W-1:0]     s3_pw;
  logic signed [PE_W-1:0]     s3_ph;
  logic signed [16:0]         scale;

  logic signed [PC_W-1:0]     rx;
  logic signed [PC_W-1:0]     ry;
  logic signed [PE_W-1:0]     rw;
  logic signed [PE_W-1:0]     rh;
  logic signed [SAMPLE_W-1:0] left_sat;
  logic signed [SAMPLE_W-1:0] top_sat;
  logic [EXT_W-1:0]           width_sat;
  logic [EXT_W-1:0]           height_sat;

  // The whole back end moves whenever the output register can take a word
  assign adv   = !out_valid || out_ready;
  assign scale = $signed({1'b0, cfg.inv_scale});

  // Corner numerators: 2*center - size - 2*pad
  always_comb begin
    nx = (NUM_W'(det.cx) <<< 1) - NUM_W'(det.w) - (NUM_W'(cfg.pad_left) <<< 1);
    ny = (NUM_W'(det.cy) <<< 1) - NUM_W'(det.h) - (NUM_W'(cfg.pad_top) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= det_valid;
      s3_vld <= s2_vld;
    end
  end

  // Register the numerators, then the scaled products
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_meta <= det.meta;
      s2_nx   <= nx;
      s2_ny   <= ny;
      s2_w    <= det.w;
      s2_h    <= det.h;
      s3_meta <= s2_meta;
      s3_px   <= PC_W'(s2_nx) * PC_W'(scale);
      s3_py   <= PC_W'(s2_ny) * PC_W'(scale);
      s3_pw   <= PE_W'(s2_w) * PE_W'(scale);
      s3_ph   <= PE_W'(s2_h) * PE_W'(scale);
    end
  end

  // Round half up, then saturate to the field ranges
  always_comb begin
    rx = (s3_px + PC_W'(4096)) >>> 13;
    ry = (s3_py + PC_W'(4096)) >>> 13;
    rw = (s3_pw + PE_W'(2048)) >>> 12;
    rh = (s3_ph + PE_W'(2048)) >>> 12;

    if (rx > PC_W'(32767)) begin
      left_sat = 16'sh7FFF;
    end else if (rx < -PC_W'(32768)) begin
      left_sat = 16'sh8000;
    end else begin
      left_sat = rx[SAMPLE_W-1:0];
    end

    if (ry > PC_W'(32767)) begin
      top_sat = 16'sh7FFF;
    end else if (ry < -PC_W'(32768)) begin
      top_sat = 16'sh8000;
    end else begin
      top_sat = ry[SAMPLE_W-1:0];
    end

    if (rw < 0) begin
      width_sat = '0;
    end else if (rw > PE_W'(32767)) begin
      width_sat = 15'h7FFF;
    end else begin
      width_sat = rw[EXT_W-1:0];
    end

    if (rh < 0) begin
      height_sat = '0;
    end else if (rh > PE_W'(32767)) begin
      height_sat = 15'h7FFF;
    end else begin
      height_sat = rh[EXT_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      anchor_id  <= s3_meta.anchor;
      class_id   <= CLASS_ID_W'(s3_meta.cls);
      confidence <= s3_meta.score;
      box_left   <= left_sat;
      box_top    <= top_sat;
      box_width  <= width_sat;
      box_height <= height_sat;
    end
  end

endmodule

// ----- rtl/core/detector_head_argmax_box_decode.sv -----
// Results pass the queue, read stage, numerator, product and output registers.
// Throughput: one value per cycle unless the output stalls; the per-anchor
// RAM read-modify-write completes each cycle, last write forwarded to the next read.
// A 4-entry queue absorbs up to four values while the output register is stalled.
// Reset (synchronous, active high) empties the queue and pipeline and loads the
// register defaults; box and score RAMs are not cleared and must be written first.
`timescale 1ns / 1ps

module detector_head_argmax_box_decode #(
  parameter int unsigned MAX_ANCHORS = dhab_pkg::MAX_ANCHORS_DEF,
  parameter int unsigned MAX_CLASSES = dhab_pkg::MAX_CLASSES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [dhab_pkg::CH_W-1:0]            channel,
  input  logic [dhab_pkg::ANCHOR_W-1:0]        anchor,
  input  logic signed [dhab_pkg::SAMPLE_W-1:0] sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [dhab_pkg::ANCHOR_W-1:0]        anchor_id,
  output logic [dhab_pkg::CLASS_ID_W-1:0]      class_id,
  output logic [dhab_pkg::SCORE_W-1:0]         confidence,
  output logic signed [dhab_pkg::SAMPLE_W-1:0] box_left,
  output logic signed [dhab_pkg::SAMPLE_W-1:0] box_top,
  output logic [dhab_pkg::EXT_W-1:0]           box_width,
  output logic [dhab_pkg::EXT_W-1:0]           box_height,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dhab_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dhab_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import dhab_pkg::*;

  cfg_t  cfg;
  item_t head;
  logic  head_valid;
  logic  pop;
  logic  adv;
  logic  det_valid;
  det_t  det;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold   <= 15'd8192;
      cfg.class_count <= 8'd80;
      cfg.inv_scale   <= 16'd4096;
      cfg.pad_left    <= '0;
      cfg.pad_top     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD:   cfg.threshold   <= cfg_data[SCORE_W-1:0];
        REG_CLASS_COUNT: cfg.class_count <= cfg_data[CH_W-1:0];
        REG_INV_SCALE:   cfg.inv_scale   <= cfg_data;
        REG_PAD_LEFT:    cfg.pad_left    <= $signed(cfg_data);
        REG_PAD_TOP:     cfg.pad_top     <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  dhab_front #(
    .MAX_ANCHORS (MAX_ANCHORS),
    .MAX_CLASSES (MAX_CLASSES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .channel    (channel),
    .anchor     (anchor),
    .sample     (sample),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  dhab_score #(
    .MAX_ANCHORS (MAX_ANCHORS),
    .MAX_CLASSES (MAX_CLASSES)
  ) u_score (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .cfg        (cfg),
    .det_valid  (det_valid),
    .det        (det)
  );

  dhab_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .adv        (adv),
    .det_valid  (det_valid),
    .det        (det),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .anchor_id  (anchor_id),
    .class_id   (class_id),
    .confidence (confidence),
    .box_left   (box_left),
    .box_top    (box_top),
    .box_width  (box_width),
    .box_height (box_height)
  );

endmodule

// ----- rtl/core/dhab_checker.sv -----
// Port-level checks for the detector head argmax and box decode block,
// bound to the top level. Depends on dhab_pkg.
`timescale 1ns / 1ps

module dhab_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [dhab_pkg::ANCHOR_W-1:0]        anchor_id,
  input logic [dhab_pkg::CLASS_ID_W-1:0]      class_id,
  input logic [dhab_pkg::SCORE_W-1:0]         confidence,
  input logic signed [dhab_pkg::SAMPLE_W-1:0] box_left,
  input logic signed [dhab_pkg::SAMPLE_W-1:0] box_top,
  input logic [dhab_pkg::EXT_W-1:0]           box_width,
  input logic [dhab_pkg::EXT_W-1:0]           box_height,
  input logic                                 cfg_ready
);

  // Reset empties the queue and drops any pending result
  a_reset_clears: assert property (@(posedge clk) rst |=> in_ready && !out_valid)
    else $error("queue or output not cleared by reset");

  // A detection always carries a score above a non-negative threshold
  a_conf_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> confidence != '0)
    else $error("detection with zero confidence");

  // Configuration writes are never back-pressured
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) !rst |-> cfg_ready)
    else $error("configuration port stalled");

  // A stalled result holds its transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(anchor_id) && $stable(class_id) &&
    $stable(confidence) && $stable(box_left) && $stable(box_top) &&
    $stable(box_width) && $stable(box_height))
    else $error("output transaction changed while stalled");

endmodule

bind detector_head_argmax_box_decode dhab_checker u_dhab_checker (.*);
